// ===== hw/rtl/chdc_pkg.sv =====
// Shared types, register indexes, codes and reset values for the coin hopper
// dispense controller. Used by every module in hw/rtl; depends on nothing.
package chdc_pkg;

  localparam int CNT_W     = 16;
  localparam int SINCE_W   = 11;
  localparam int ELAPSED_W = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int COIN_W    = 10;

  localparam logic [CNT_W-1:0]     CNT_MAX     = '1;
  localparam logic [SINCE_W-1:0]   SINCE_MAX   = '1;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [9:0]  COIN_VALUE_RST   = 10'd5;
  localparam logic [9:0]  DEBOUNCE_RST     = 10'd40;
  localparam logic [19:0] TIMEOUT_RST      = 20'd30000;
  localparam logic [15:0] PULSE_WAIT_RST   = 16'd5000;
  localparam logic [15:0] SPACING_RST      = 16'd160;
  localparam logic [7:0]  SETTLE_RST       = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COIN_VALUE = 3'd0,
    REG_DEBOUNCE   = 3'd1,
    REG_TIMEOUT    = 3'd2,
    REG_PULSE_WAIT = 3'd3,
    REG_SPACING    = 3'd4,
    REG_SETTLE     = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_SUCCESS  = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_INVALID  = 3'd3,
    ST_BUSY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_WAIT   = 2'd2,
    PH_SPACE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_DIV   = 2'd1,
    SEQ_APPLY = 2'd2
  } seq_t;

  typedef struct packed {
    logic [9:0]  coin_value;
    logic [9:0]  debounce_ms;
    logic [19:0] run_limit_ms;
    logic [15:0] pulse_wait_ms;
    logic [15:0] spacing_ms;
    logic [7:0]  settle_ms;
  } cfg_t;

  typedef struct packed {
    logic pulse_edge;
    logic start_request;
    logic start_ok;
  } tick_t;

  typedef struct packed {
    logic [CNT_W-1:0] coins;
    logic             exact;
  } div_result_t;

  typedef struct packed {
    logic             motor_on;
    logic             busy_res;
    logic [CNT_W-1:0] coins_dispensed;
    logic             done_res;
    status_t          status;
  } res_t;

  function automatic logic [CNT_W-1:0] sat16_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== hw/rtl/chdc_divider.sv =====
// Shift-subtract divider: amount / coin value, one quotient bit per cycle.
// Depends on chdc_pkg for the result type and count width.
module chdc_divider #(
  parameter int AMOUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [AMOUNT_BITS-1:0]        dividend,
  input  logic [chdc_pkg::COIN_W-1:0]   divisor,
  output logic                          done,
  output chdc_pkg::div_result_t         result
);

  localparam int CW = $clog2(AMOUNT_BITS + 1);

  logic                          busy;
  logic [CW-1:0]                 cnt;
  logic [AMOUNT_BITS-1:0]        shreg;
  logic [AMOUNT_BITS-1:0]        quot;
  logic [chdc_pkg::COIN_W-1:0]   rem;
  logic [chdc_pkg::COIN_W:0]     trial;
  logic                          ge;
  logic [chdc_pkg::COIN_W:0]     diff;

  assign trial = {rem, shreg[AMOUNT_BITS-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(AMOUNT_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      quot  <= '0;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      quot  <= {quot[AMOUNT_BITS-2:0], ge};
      rem   <= ge ? diff[chdc_pkg::COIN_W-1:0] : trial[chdc_pkg::COIN_W-1:0];
    end
  end

  // Clamp the coin count to the 16-bit run counters.
  always_comb begin
    result.coins = (32'(quot) > 32'(chdc_pkg::CNT_MAX)) ? chdc_pkg::CNT_MAX
                                                         : chdc_pkg::CNT_W'(quot);
    result.exact = (rem == '0);
  end

endmodule

// ===== hw/rtl/chdc_core.sv =====
// Dispense state and per-tick update: debounce, pulse counts, run phases.
// Depends on chdc_pkg; state advances only on the commit strobe.
module chdc_core #(
  parameter int TOTAL_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           commit,
  input  chdc_pkg::tick_t                tick,
  input  logic [chdc_pkg::CNT_W-1:0]     coins_in,
  input  chdc_pkg::cfg_t                 cfg,
  output logic                           phase_idle,
  output chdc_pkg::res_t                 res,
  output logic [31:0]                    pulse_total
);

  chdc_pkg::phase_t                  phase, phase_next;
  logic [chdc_pkg::SINCE_W-1:0]      since, since_next;
  logic [TOTAL_BITS-1:0]             total, total_next;
  logic [chdc_pkg::CNT_W-1:0]        run_cnt, run_cnt_next;
  logic [chdc_pkg::CNT_W-1:0]        needed, needed_next;
  logic [chdc_pkg::CNT_W-1:0]        credited, credited_next;
  logic [chdc_pkg::CNT_W-1:0]        timer, timer_next;
  logic [chdc_pkg::ELAPSED_W-1:0]    elapsed, elapsed_next;
  logic                              relay, relay_next;

  logic [chdc_pkg::SINCE_W-1:0]      since_inc;
  logic [chdc_pkg::CNT_W-1:0]        timer_inc;
  logic                              acc;
  logic                              finish;
  logic                              done;
  chdc_pkg::status_t                 status;

  assign phase_idle = (phase == chdc_pkg::PH_IDLE);

  always_comb begin
    since_inc = (since == chdc_pkg::SINCE_MAX) ? since : since + 1'b1;
    acc       = tick.pulse_edge && (since_inc > {1'b0, cfg.debounce_ms});
    timer_inc = chdc_pkg::sat16_inc(timer);

    since_next    = acc ? '0 : since_inc;
    total_next    = acc ? total + 1'b1 : total;
    run_cnt_next  = acc ? chdc_pkg::sat16_inc(run_cnt) : run_cnt;
    phase_next    = phase;
    needed_next   = needed;
    credited_next = credited;
    timer_next    = timer;
    elapsed_next  = elapsed;
    relay_next    = relay;
    finish        = 1'b0;
    done          = 1'b0;
    status        = chdc_pkg::ST_NONE;

    if (tick.start_request && phase == chdc_pkg::PH_IDLE) begin
      if (!tick.start_ok) begin
        done   = 1'b1;
        status = chdc_pkg::ST_INVALID;
      end else begin
        needed_next   = coins_in;
        phase_next    = chdc_pkg::PH_SETTLE;
        timer_next    = '0;
        relay_next    = 1'b0;
        run_cnt_next  = '0;
        credited_next = '0;
        elapsed_next  = '0;
      end
    end else begin
      if (tick.start_request) begin
        done   = 1'b1;
        status = chdc_pkg::ST_BUSY;
      end
      unique case (phase) inside
        chdc_pkg::PH_IDLE: begin
        end
        chdc_pkg::PH_SETTLE: begin
          timer_next = timer_inc;
          if (timer_inc >= {8'b0, cfg.settle_ms}) begin
            run_cnt_next = '0;
            elapsed_next = '0;
            relay_next   = 1'b1;
            phase_next   = chdc_pkg::PH_WAIT;
            timer_next   = '0;
          end
        end
        chdc_pkg::PH_WAIT, chdc_pkg::PH_SPACE: begin
          elapsed_next = (elapsed == chdc_pkg::ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
          if (elapsed_next >= cfg.run_limit_ms || run_cnt_next >= needed) begin
            finish = 1'b1;
          end else if (phase == chdc_pkg::PH_WAIT) begin
            if (acc) begin
              credited_next = chdc_pkg::sat16_inc(credited);
              relay_next    = 1'b0;
              phase_next    = chdc_pkg::PH_SPACE;
              timer_next    = '0;
            end else if (timer >= cfg.pulse_wait_ms) begin
              relay_next = 1'b0;
              phase_next = chdc_pkg::PH_SPACE;
              timer_next = '0;
            end else begin
              timer_next = timer_inc;
            end
          end else begin
            timer_next = timer_inc;
            if (timer_inc >= cfg.spacing_ms) begin
              if (credited >= needed) begin
                finish = 1'b1;
              end else begin
                relay_next = 1'b1;
                phase_next = chdc_pkg::PH_WAIT;
                timer_next = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
      if (finish) begin
        relay_next = 1'b0;
        phase_next = chdc_pkg::PH_IDLE;
        timer_next = '0;
        done       = 1'b1;
        status     = (run_cnt_next == needed) ? chdc_pkg::ST_SUCCESS
                                              : chdc_pkg::ST_MISMATCH;
      end
    end

    res.motor_on        = relay_next;
    res.busy_res        = (phase_next != chdc_pkg::PH_IDLE);
    res.coins_dispensed = run_cnt_next;
    res.done_res        = done;
    res.status          = status;
    pulse_total         = 32'(total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= chdc_pkg::PH_IDLE;
      since    <= '0;
      total    <= '0;
      run_cnt  <= '0;
      needed   <= '0;
      credited <= '0;
      timer    <= '0;
      elapsed  <= '0;
      relay    <= 1'b0;
    end else if (commit) begin
      phase    <= phase_next;
      since    <= since_next;
      total    <= total_next;
      run_cnt  <= run_cnt_next;
      needed   <= needed_next;
      credited <= credited_next;
      timer    <= timer_next;
      elapsed  <= elapsed_next;
      relay    <= relay_next;
    end
  end

endmodule

// ===== hw/rtl/coin_hopper_dispense_controller.sv =====
// Coin hopper dispense controller, one input item per millisecond tick.
// A tick that skips the divider goes from accept through SEQ_APPLY to the result;
// a start that runs the shift-subtract divider passes SEQ_DIV before SEQ_APPLY.
// A new item is taken only once the last one is committed, and SEQ_APPLY waits
// while the output register is still full.
// Reset: synchronous rst clears the run state and counters and reloads config.
module coin_hopper_dispense_controller #(
  parameter int AMOUNT_BITS = 16,
  parameter int TOTAL_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [chdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [chdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Tick items in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // low bit up: pulse_edge, start_request, amount[AMOUNT_BITS], zero fill
  input  logic [((AMOUNT_BITS+9)/8)*8-1:0]    s_axis_tdata,
  // Result items out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // low bit up: motor_on, busy_res, coins_dispensed[16], done_res,
  // status[3], pulse_total[32], zero fill
  output logic [55:0]                         m_axis_tdata
);

  localparam int AMT_LO = 2;
  localparam int AMT_HI = AMT_LO + AMOUNT_BITS - 1;

  chdc_pkg::cfg_t           cfg;
  chdc_pkg::seq_t           seq, seq_next;
  chdc_pkg::tick_t          tick;
  chdc_pkg::div_result_t    div_res;
  chdc_pkg::res_t           res;

  logic                     in_accept;
  logic                     out_free;
  logic                     commit;
  logic                     div_start;
  logic                     div_done;
  logic                     phase_idle;
  logic [31:0]              pulse_total;

  // Held copy of the accepted tick.
  logic                     edge_r;
  logic                     start_r;
  logic                     use_div;

  // Config registers; write them only while no item is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coin_value    <= chdc_pkg::COIN_VALUE_RST;
      cfg.debounce_ms   <= chdc_pkg::DEBOUNCE_RST;
      cfg.run_limit_ms  <= chdc_pkg::TIMEOUT_RST;
      cfg.pulse_wait_ms <= chdc_pkg::PULSE_WAIT_RST;
      cfg.spacing_ms    <= chdc_pkg::SPACING_RST;
      cfg.settle_ms     <= chdc_pkg::SETTLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chdc_pkg::REG_COIN_VALUE: cfg.coin_value    <= cfg_data[9:0];
        chdc_pkg::REG_DEBOUNCE:   cfg.debounce_ms   <= cfg_data[9:0];
        chdc_pkg::REG_TIMEOUT:    cfg.run_limit_ms  <= cfg_data[19:0];
        chdc_pkg::REG_PULSE_WAIT: cfg.pulse_wait_ms <= cfg_data[15:0];
        chdc_pkg::REG_SPACING:    cfg.spacing_ms    <= cfg_data[15:0];
        chdc_pkg::REG_SETTLE:     cfg.settle_ms     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = (seq == chdc_pkg::SEQ_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Launch the divider only for a start that can pass: run idle, nonzero
  // coin value and amount. Everything else goes straight to the update.
  assign div_start = in_accept && s_axis_tdata[1] && phase_idle &&
                     (cfg.coin_value != '0) && (s_axis_tdata[AMT_HI:AMT_LO] != '0);

  // Sequencer: accept, optionally divide, then commit once the output
  // register has room.
  always_comb begin
    seq_next = seq;
    commit   = 1'b0;
    unique case (seq)
      chdc_pkg::SEQ_IDLE: begin
        if (in_accept) begin
          seq_next = div_start ? chdc_pkg::SEQ_DIV : chdc_pkg::SEQ_APPLY;
        end
      end
      chdc_pkg::SEQ_DIV: begin
        if (div_done) begin
          seq_next = chdc_pkg::SEQ_APPLY;
        end
      end
      chdc_pkg::SEQ_APPLY: begin
        if (out_free) begin
          commit   = 1'b1;
          seq_next = chdc_pkg::SEQ_IDLE;
        end
      end
      default: seq_next = chdc_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= chdc_pkg::SEQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      edge_r  <= s_axis_tdata[0];
      start_r <= s_axis_tdata[1];
      use_div <= div_start;
    end
  end

  always_comb begin
    tick.pulse_edge    = edge_r;
    tick.start_request = start_r;
    tick.start_ok      = use_div && div_res.exact;
  end

  chdc_divider #(
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_axis_tdata[AMT_HI:AMT_LO]),
    .divisor  (cfg.coin_value),
    .done     (div_done),
    .result   (div_res)
  );

  chdc_core #(
    .TOTAL_BITS (TOTAL_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .commit      (commit),
    .tick        (tick),
    .coins_in    (div_res.coins),
    .cfg         (cfg),
    .phase_idle  (phase_idle),
    .res         (res),
    .pulse_total (pulse_total)
  );

  // Output register: hold a result until taken, load on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_axis_tdata <= {2'b00, pulse_total, res.status, res.done_res,
                       res.coins_dispensed, res.busy_res, res.motor_on};
    end
  end

endmodule

// ===== verif/coin_hopper_dispense_controller_tb.sv =====
// Self-checking testbench for coin_hopper_dispense_controller: drives millisecond
// ticks, predicts every result item in SystemVerilog and compares field by field.
// Depends on chdc_pkg and the controller RTL only.
module coin_hopper_dispense_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AMT_W       = 16;
  localparam int IN_W        = ((AMT_W + 9) / 8) * 8;
  localparam int OUT_W       = 56;
  localparam int HALF_PERIOD = 5;
  // Cycles to let pass after the last result before touching the registers;
  // this is comfortably longer than the divider path.
  localparam int QUIET_CYCLES = 40;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_PRINTS   = 40;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_TICKS  = 88;

  // One millisecond tick as offered to the block.
  typedef struct {
    logic             pulse;
    logic             start_req;
    logic [AMT_W-1:0] amount;
  } tick_item_t;

  // What the block reports after a tick.
  typedef struct {
    logic              relay;
    logic              busy;
    logic [15:0]       coins;
    logic              done;
    chdc_pkg::status_t status;
    logic [31:0]       total;
  } tick_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [chdc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [chdc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // low bit up: pulse_edge, start_request, amount[16], zero fill
  logic [IN_W-1:0]                 s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // low bit up: motor_on, busy_res, coins_dispensed[16], done_res, status[3],
  // pulse_total[32], zero fill
  logic [OUT_W-1:0]                m_axis_tdata;

  coin_hopper_dispense_controller i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Ticks waiting to be offered, and results the hopper model says must come.
  tick_item_t   pending_ticks[$];
  tick_result_t expected_results[$];
  tick_item_t   on_wire;

  int fail_count    = 0;
  int results_seen  = 0;
  int ticks_taken   = 0;
  int settings_used = 0;
  int status_count[5] = '{default: 0};

  // ---------------------------------------------------------------------------
  // Hopper model: settings and run state kept at the block's own widths.
  // ---------------------------------------------------------------------------
  chdc_pkg::cfg_t   hop_cfg;
  chdc_pkg::phase_t hop_phase;
  logic [10:0]      hop_since;
  logic [31:0]      hop_total;
  logic [15:0]      hop_run_cnt;
  logic [15:0]      hop_needed;
  logic [15:0]      hop_credited;
  logic [15:0]      hop_timer;
  logic [19:0]      hop_elapsed;
  logic             hop_relay;

  task automatic hopper_reset();
    hop_cfg.coin_value    = chdc_pkg::COIN_VALUE_RST;
    hop_cfg.debounce_ms   = chdc_pkg::DEBOUNCE_RST;
    hop_cfg.run_limit_ms  = chdc_pkg::TIMEOUT_RST;
    hop_cfg.pulse_wait_ms = chdc_pkg::PULSE_WAIT_RST;
    hop_cfg.spacing_ms    = chdc_pkg::SPACING_RST;
    hop_cfg.settle_ms     = chdc_pkg::SETTLE_RST;
    hop_phase    = chdc_pkg::PH_IDLE;
    hop_since    = '0;
    hop_total    = '0;
    hop_run_cnt  = '0;
    hop_needed   = '0;
    hop_credited = '0;
    hop_timer    = '0;
    hop_elapsed  = '0;
    hop_relay    = 1'b0;
  endtask

  // Advance the hopper by one tick and return what the block must report.
  function automatic tick_result_t hopper_tick(input tick_item_t t);
    tick_result_t r;
    logic took;
    logic finish;
    took     = 1'b0;
    finish   = 1'b0;
    r.done   = 1'b0;
    r.status = chdc_pkg::ST_NONE;

    // Debounce: age the last pulse first, then judge this tick's edge.
    if (hop_since != '1) hop_since++;
    if (t.pulse && hop_since > hop_cfg.debounce_ms) begin
      took      = 1'b1;
      hop_since = '0;
      hop_total++;
      if (hop_run_cnt != '1) hop_run_cnt++;
    end

    if (t.start_req && hop_phase == chdc_pkg::PH_IDLE) begin
      r.done = 1'b1;
      if (hop_cfg.coin_value == 0 || t.amount == 0 ||
          (t.amount % hop_cfg.coin_value) != 0) begin
        r.status = chdc_pkg::ST_INVALID;
      end else begin
        // A pulse taken on the start tick belongs to no run.
        hop_needed   = t.amount / hop_cfg.coin_value;
        hop_phase    = chdc_pkg::PH_SETTLE;
        hop_timer    = '0;
        hop_relay    = 1'b0;
        hop_run_cnt  = '0;
        hop_credited = '0;
        hop_elapsed  = '0;
        r.done       = 1'b0;
      end
    end else begin
      if (t.start_req) begin
        r.done   = 1'b1;
        r.status = chdc_pkg::ST_BUSY;
      end
      case (hop_phase) inside
        chdc_pkg::PH_SETTLE: begin
          if (hop_timer != '1) hop_timer++;
          if (hop_timer >= hop_cfg.settle_ms) begin
            hop_run_cnt = '0;
            hop_elapsed = '0;
            hop_relay   = 1'b1;
            hop_phase   = chdc_pkg::PH_WAIT;
            hop_timer   = '0;
          end
        end
        chdc_pkg::PH_WAIT, chdc_pkg::PH_SPACE: begin
          if (hop_elapsed != '1) hop_elapsed++;
          if (hop_elapsed >= hop_cfg.run_limit_ms || hop_run_cnt >= hop_needed) begin
            finish = 1'b1;
          end else if (hop_phase == chdc_pkg::PH_WAIT) begin
            if (took) begin
              // Coin seen: cut the motor on this very tick.
              if (hop_credited != '1) hop_credited++;
              hop_relay = 1'b0;
              hop_phase = chdc_pkg::PH_SPACE;
              hop_timer = '0;
            end else if (hop_timer >= hop_cfg.pulse_wait_ms) begin
              hop_relay = 1'b0;
              hop_phase = chdc_pkg::PH_SPACE;
              hop_timer = '0;
            end else if (hop_timer != '1) begin
              hop_timer++;
            end
          end else begin
            if (hop_timer != '1) hop_timer++;
            if (hop_timer >= hop_cfg.spacing_ms) begin
              if (hop_credited >= hop_needed) begin
                finish = 1'b1;
              end else begin
                hop_relay = 1'b1;
                hop_phase = chdc_pkg::PH_WAIT;
                hop_timer = '0;
              end
            end
          end
          if (finish) begin
            hop_relay = 1'b0;
            hop_phase = chdc_pkg::PH_IDLE;
            hop_timer = '0;
            r.done    = 1'b1;
            r.status  = (hop_run_cnt == hop_needed) ? chdc_pkg::ST_SUCCESS
                                                    : chdc_pkg::ST_MISMATCH;
          end
        end
        default: ;
      endcase
    end

    r.relay = hop_relay;
    r.busy  = (hop_phase != chdc_pkg::PH_IDLE);
    r.coins = hop_run_cnt;
    r.total = hop_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes and stimulus helpers for the sequence below, and the mismatch report.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input chdc_pkg::reg_idx_t idx,
                           input logic [chdc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    // No tick is in flight here, so the model may take the value at once.
    case (idx)
      chdc_pkg::REG_COIN_VALUE: hop_cfg.coin_value    = val[9:0];
      chdc_pkg::REG_DEBOUNCE:   hop_cfg.debounce_ms   = val[9:0];
      chdc_pkg::REG_TIMEOUT:    hop_cfg.run_limit_ms  = val[19:0];
      chdc_pkg::REG_PULSE_WAIT: hop_cfg.pulse_wait_ms = val[15:0];
      chdc_pkg::REG_SPACING:    hop_cfg.spacing_ms    = val[15:0];
      chdc_pkg::REG_SETTLE:     hop_cfg.settle_ms     = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [9:0] coin, input logic [9:0] debounce,
                                input logic [19:0] timeout, input logic [15:0] pulse_wait,
                                input logic [15:0] spacing, input logic [7:0] settle);
    write_reg(chdc_pkg::REG_COIN_VALUE, 20'(coin));
    write_reg(chdc_pkg::REG_DEBOUNCE,   20'(debounce));
    write_reg(chdc_pkg::REG_TIMEOUT,    timeout);
    write_reg(chdc_pkg::REG_PULSE_WAIT, 20'(pulse_wait));
    write_reg(chdc_pkg::REG_SPACING,    20'(spacing));
    write_reg(chdc_pkg::REG_SETTLE,     20'(settle));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Pick run-friendly settings so that whole runs fit into a few dozen ticks,
  // with an occasional large coin value or long overall time-out.
  task automatic random_settings(output logic [9:0] coin);
    logic [19:0] timeout;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)      coin = 10'($urandom_range(1, 6));
    else if (pick < 9) coin = 10'($urandom_range(7, 30));
    else               coin = 10'($urandom_range(31, 1000));
    timeout = ($urandom_range(0, 4) == 0) ? 20'($urandom_range(200, 1048575))
                                          : 20'($urandom_range(10, 60));
    apply_settings(coin, 10'($urandom_range(0, 3)), timeout, 16'($urandom_range(1, 6)),
                   16'($urandom_range(0, 4)), 8'($urandom_range(0, 3)));
  endtask

  function automatic void queue_tick(input logic pulse, input logic start_req,
                                     input logic [AMT_W-1:0] amount);
    tick_item_t t;
    t.pulse     = pulse;
    t.start_req = start_req;
    t.amount    = amount;
    pending_ticks.push_back(t);
  endfunction

  // Mostly whole runs (a valid start, then ticks with pulses at a random rate
  // and the odd second request), the rest noise and malformed requests.
  task automatic random_ticks(input logic [9:0] coin, input int count);
    int made;
    int sel;
    int run_len;
    int pulse_odds;
    int max_k;
    logic [AMT_W-1:0] amt;
    logic req;
    made = 0;
    while (made < count) begin
      sel   = $urandom_range(0, 9);
      max_k = 65535 / coin;
      if (sel < 7) begin
        amt = ($urandom_range(0, 9) == 0) ? AMT_W'(coin * $urandom_range(1, max_k))
                                          : AMT_W'(coin * $urandom_range(1, 4));
        queue_tick($urandom_range(0, 3) == 0, 1'b1, amt);
        run_len    = $urandom_range(8, 40);
        pulse_odds = $urandom_range(2, 4);
        for (int i = 0; i < run_len; i++) begin
          req = ($urandom_range(0, 24) == 0);
          amt = req ? AMT_W'(coin * $urandom_range(1, 3)) : AMT_W'($urandom());
          queue_tick($urandom_range(0, pulse_odds - 1) == 0, req, amt);
        end
        made += run_len + 1;
      end else if (sel < 9) begin
        run_len = $urandom_range(3, 10);
        for (int i = 0; i < run_len; i++)
          queue_tick($urandom_range(0, 1) == 1, $urandom_range(0, 2) == 0,
                     AMT_W'($urandom()));
        made += run_len;
      end else begin
        amt = ($urandom_range(0, 1) == 0) ? '0 : AMT_W'(coin * $urandom_range(1, 3) + 1);
        queue_tick(1'b0, 1'b1, amt);
        queue_tick(1'b1, 1'b0, AMT_W'($urandom()));
        made += 2;
      end
    end
  endtask

  // Hold the sender until every expected result is back, then let the block
  // settle before the registers change.
  task automatic wait_drain();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("[%0t ns] result %0d: %s got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps. Predict each
  // tick on the edge where it is taken.
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        tick_result_t r;
        r = hopper_tick(on_wire);
        expected_results.push_back(r);
        status_count[int'(r.status)]++;
        ticks_taken++;
      end
      // Offer a new tick only once the current one is gone.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          on_wire = pending_ticks.pop_front();
          s_axis_tdata  <= {6'b0, on_wire.amount, on_wire.start_req, on_wire.pulse};
          s_axis_tvalid <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a mode picked anew at random intervals (always
  // ready, coin-flip, or a fixed duty pattern). Twice in the run it holds off
  // for a long stretch so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int         hold_left;
  int         rx_count;
  int         mode_left;
  logic [1:0] stall_mode;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left  = 0;
      rx_count   = 0;
      mode_left  = 0;
      stall_mode = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rx_count++;
        if (rx_count == 150 || rx_count == 420) hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        stall_mode = 2'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          2'd2:    m_axis_tready <= ($urandom_range(0, 1) == 1);
          2'd3:    m_axis_tready <= (mode_left % 4) != 0;
          default: m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result item", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[0] !== want.relay)
          report_mismatch("motor_on", 32'(m_axis_tdata[0]), 32'(want.relay));
        if (m_axis_tdata[1] !== want.busy)
          report_mismatch("busy_res", 32'(m_axis_tdata[1]), 32'(want.busy));
        if (m_axis_tdata[17:2] !== want.coins)
          report_mismatch("coins_dispensed", 32'(m_axis_tdata[17:2]), 32'(want.coins));
        if (m_axis_tdata[18] !== want.done)
          report_mismatch("done_res", 32'(m_axis_tdata[18]), 32'(want.done));
        if (m_axis_tdata[21:19] !== want.status)
          report_mismatch("status", 32'(m_axis_tdata[21:19]), 32'(want.status));
        if (m_axis_tdata[53:22] !== want.total)
          report_mismatch("pulse_total", m_axis_tdata[53:22], want.total);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed ticks under tight and extreme settings, then
  // random phases, each starting from a drained block.
  // ---------------------------------------------------------------------------
  initial begin
    logic [9:0] coin;
    hopper_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Tight settings: coin 5, debounce 2, time-out 12, wait 2, spacing 1, settle 2.
    apply_settings(10'd5, 10'd2, 20'd12, 16'd2, 16'd1, 8'd2);
    @(negedge clk);
    queue_tick(1'b0, 1'b0, 16'hFFFF);  // idle tick, amount ignored
    queue_tick(1'b1, 1'b0, 16'h0000);  // edge inside the debounce window
    queue_tick(1'b1, 1'b0, 16'h0000);  // first edge past it
    queue_tick(1'b0, 1'b1, 16'd0);     // zero amount
    queue_tick(1'b0, 1'b1, 16'd7);     // not a multiple of the coin
    queue_tick(1'b1, 1'b1, 16'd15);    // start with a pulse on the same tick
    queue_tick(1'b0, 1'b1, 16'd10);    // request while settling
    queue_tick(1'b0, 1'b0, 16'd0);
    queue_tick(1'b1, 1'b0, 16'd0);     // coin seen: relay cut at once
    queue_tick(1'b0, 1'b0, 16'd0);
    queue_tick(1'b0, 1'b0, 16'd0);
    queue_tick(1'b0, 1'b0, 16'd0);
    queue_tick(1'b0, 1'b0, 16'd0);     // per-coin wait runs out
    for (int i = 0; i < 6; i++) queue_tick(i[0], 1'b0, 16'd0);
    queue_tick(1'b0, 1'b1, 16'd5);     // single coin run
    queue_tick(1'b0, 1'b0, 16'd0);
    queue_tick(1'b0, 1'b0, 16'd0);
    queue_tick(1'b0, 1'b0, 16'd0);
    queue_tick(1'b1, 1'b0, 16'd0);
    queue_tick(1'b0, 1'b0, 16'd0);
    queue_tick(1'b0, 1'b0, 16'd0);
    wait_drain();

    // Upper extremes of every register; the run started here stays in settle.
    apply_settings(10'd1000, 10'd1000, 20'd1048575, 16'd65535, 16'd65535, 8'd255);
    @(negedge clk);
    queue_tick(1'b0, 1'b1, 16'd1001);
    queue_tick(1'b0, 1'b1, 16'd65000);
    queue_tick(1'b1, 1'b1, 16'd64000);
    queue_tick(1'b0, 1'b0, 16'd0);
    wait_drain();

    // Lower extremes: the pending run times out on its first running tick,
    // then a full-range amount with a one-unit coin.
    apply_settings(10'd1, 10'd0, 20'd1, 16'd1, 16'd0, 8'd0);
    @(negedge clk);
    queue_tick(1'b0, 1'b0, 16'd0);
    queue_tick(1'b1, 1'b0, 16'd0);
    queue_tick(1'b1, 1'b0, 16'd0);
    queue_tick(1'b0, 1'b1, 16'hFFFF);
    queue_tick(1'b1, 1'b0, 16'd0);
    queue_tick(1'b0, 1'b0, 16'd0);
    queue_tick(1'b0, 1'b0, 16'd0);
    wait_drain();

    // Zero coin value rejects every request.
    write_reg(chdc_pkg::REG_COIN_VALUE, 20'd0);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    @(negedge clk);
    queue_tick(1'b0, 1'b1, 16'd10);
    queue_tick(1'b1, 1'b1, 16'd0);
    wait_drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      random_settings(coin);
      @(negedge clk);
      random_ticks(coin, PHASE_TICKS);
      wait_drain();
    end

    $display("Covered %0d ticks under %0d register settings: %0d runs ok, %0d %s",
             ticks_taken, settings_used, status_count[int'(chdc_pkg::ST_SUCCESS)],
             status_count[int'(chdc_pkg::ST_MISMATCH)], "short or timed out,");
    $display("%0d invalid requests, %0d refused while busy, %0d pulses taken in total.",
             status_count[int'(chdc_pkg::ST_INVALID)],
             status_count[int'(chdc_pkg::ST_BUSY)], hop_total);
    if (fail_count == 0) begin
      $display("** coin_hopper_dispense_controller: PASSED **");
    end else begin
      $display("%0d mismatches in %0d results", fail_count, results_seen);
      $display("** coin_hopper_dispense_controller: FAILED **");
    end
    $finish;
  end

  // Watchdog: ends the simulation if the sequence has not finished first.
  initial begin
    #2_000_000;
    $display("Watchdog expired with %0d results still expected", expected_results.size());
    $display("** coin_hopper_dispense_controller: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/chdc_pkg.sv
hw/rtl/chdc_divider.sv
hw/rtl/chdc_core.sv
hw/rtl/coin_hopper_dispense_controller.sv
verif/coin_hopper_dispense_controller_tb.sv
